/* rtl/spb_pkg.sv */
// ----------------------------------------------------------------------------
// spb_pkg
// Shared types and constants for the sprite pixel blitter.
// ----------------------------------------------------------------------------
package spb_pkg;

  localparam int DEF_FRAME_WIDTH     = 1024;
  localparam int DEF_FRAME_HEIGHT    = 768;
  localparam int DEF_MAX_SPRITE_SIDE = 4096;

  // field widths
  localparam int OFFSET_W  = 12;
  localparam int SIDE_W    = 13;
  localparam int RADIUS_W  = 11;
  localparam int COLOR_W   = 32;
  localparam int ORIGIN_W  = 16;
  localparam int ADDR_W    = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // frame coordinates stay below 4096
  localparam int COORD_W   = 12;
  localparam int FRAME_C_W = 18;
  localparam int DELTA_W   = 13;
  localparam int SQ_W      = 24;
  localparam int PROD_W    = 25;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam int         RGB_W        = 24;

  typedef enum logic [1:0] {
    SHAPE_BITMAP = 2'd0,
    SHAPE_RECT   = 2'd1,
    SHAPE_CIRCLE = 2'd2
  } spb_shape_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHAPE_KIND    = 3'd0,
    REG_BOX_WIDTH     = 3'd1,
    REG_BOX_HEIGHT    = 3'd2,
    REG_CIRCLE_RADIUS = 3'd3,
    REG_SHAPE_COLOR   = 3'd4,
    REG_FILL_RECT     = 3'd5,
    REG_ORIGIN_X      = 3'd6,
    REG_ORIGIN_Y      = 3'd7
  } spb_cfg_idx_t;

endpackage

/* rtl/sprite_pixel_blit_core.sv */
// ----------------------------------------------------------------------------
// sprite_pixel_blit_core
// Turns one sprite-local offset into a clipped frame address and opaque colour.
// Throughput: one request per cycle while the output is not stalled; four
// register stages (box and clip arithmetic, squares and row product, circle
// test and address add, output).
// A stalled output only holds the stages behind it that are full.
// Reset (synchronous, rst_n low) empties the pipeline and clears the configuration registers.
// ----------------------------------------------------------------------------
module sprite_pixel_blit_core #(
  parameter int FRAME_WIDTH     = spb_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT    = spb_pkg::DEF_FRAME_HEIGHT,
  parameter int MAX_SPRITE_SIDE = spb_pkg::DEF_MAX_SPRITE_SIDE
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spb_pkg::OFFSET_W-1:0]    in_offset_col,
  input  logic [spb_pkg::OFFSET_W-1:0]    in_offset_row,
  input  logic [spb_pkg::COLOR_W-1:0]     in_texel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spb_pkg::ADDR_W-1:0]      out_pixel_address,
  output logic [spb_pkg::COLOR_W-1:0]     out_pixel_color
);
  import spb_pkg::*;

  localparam logic [SIDE_W-1:0]           MaxSide = SIDE_W'(MAX_SPRITE_SIDE);
  localparam logic signed [FRAME_C_W-1:0] FrameW  = FRAME_C_W'(FRAME_WIDTH);
  localparam logic signed [FRAME_C_W-1:0] FrameH  = FRAME_C_W'(FRAME_HEIGHT);
  localparam logic [PROD_W-1:0]           RowMul  = PROD_W'(FRAME_WIDTH);

  // configuration registers
  logic [1:0]                  shape_kind_r;
  logic [SIDE_W-1:0]           box_width_r;
  logic [SIDE_W-1:0]           box_height_r;
  logic [RADIUS_W-1:0]         circle_radius_r;
  logic [COLOR_W-1:0]          shape_color_r;
  logic                        fill_rect_r;
  logic signed [ORIGIN_W-1:0]  origin_x_r;
  logic signed [ORIGIN_W-1:0]  origin_y_r;
  logic [2*RADIUS_W-1:0]       radius_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_kind_r    <= '0;
      box_width_r     <= '0;
      box_height_r    <= '0;
      circle_radius_r <= '0;
      shape_color_r   <= '0;
      fill_rect_r     <= 1'b0;
      origin_x_r      <= '0;
      origin_y_r      <= '0;
    end else if (cfg_valid) begin
      unique case (spb_cfg_idx_t'(cfg_index))
        REG_SHAPE_KIND:    shape_kind_r    <= cfg_data[1:0];
        REG_BOX_WIDTH:     box_width_r     <= cfg_data[SIDE_W-1:0];
        REG_BOX_HEIGHT:    box_height_r    <= cfg_data[SIDE_W-1:0];
        REG_CIRCLE_RADIUS: circle_radius_r <= cfg_data[RADIUS_W-1:0];
        REG_SHAPE_COLOR:   shape_color_r   <= cfg_data[COLOR_W-1:0];
        REG_FILL_RECT:     fill_rect_r     <= cfg_data[0];
        REG_ORIGIN_X:      origin_x_r      <= cfg_data[ORIGIN_W-1:0];
        REG_ORIGIN_Y:      origin_y_r      <= cfg_data[ORIGIN_W-1:0];
      endcase
    end
  end

  // squared radius is registered from the radius register, following it in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_sq_r <= '0;
    end else begin
      radius_sq_r <= circle_radius_r * circle_radius_r;
    end
  end

  // pipeline flow control: a stage moves when it is empty or the next one moves
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic adv1, adv2, adv3, adv_out;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv3     = !v3_r || adv_out;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  // stage 1: box test, frame position, circle deltas, border test
  logic [SIDE_W-1:0]           side_w, side_h;
  logic                        hit1_nxt, border1_nxt;
  logic signed [FRAME_C_W-1:0] fx1_nxt, fy1_nxt;
  logic signed [DELTA_W-1:0]   dx1_nxt, dy1_nxt;
  logic                        is_bitmap, is_rect, is_circle;

  assign is_bitmap = (shape_kind_r == SHAPE_BITMAP);
  assign is_rect   = (shape_kind_r == SHAPE_RECT);
  assign is_circle = (shape_kind_r == SHAPE_CIRCLE);

  always_comb begin
    if (is_circle) begin
      side_w = ({1'b0, circle_radius_r, 1'b1} > MaxSide) ? MaxSide
                                                           : {1'b0, circle_radius_r, 1'b1};
      side_h = side_w;
    end else begin
      side_w = (box_width_r > MaxSide) ? MaxSide : box_width_r;
      side_h = (box_height_r > MaxSide) ? MaxSide : box_height_r;
    end
    hit1_nxt = (is_bitmap || is_rect || is_circle)
               && ({1'b0, in_offset_col} < side_w)
               && ({1'b0, in_offset_row} < side_h);
    border1_nxt = (in_offset_col == '0) || (in_offset_row == '0)
                  || ({1'b0, in_offset_col} == side_w - SIDE_W'(1))
                  || ({1'b0, in_offset_row} == side_h - SIDE_W'(1));
    fx1_nxt = FRAME_C_W'(origin_x_r) + $signed({6'b0, in_offset_col});
    fy1_nxt = FRAME_C_W'(origin_y_r) + $signed({6'b0, in_offset_row});
    dx1_nxt = $signed({1'b0, in_offset_col}) - $signed({2'b0, circle_radius_r});
    dy1_nxt = $signed({1'b0, in_offset_row}) - $signed({2'b0, circle_radius_r});
  end

  logic                        hit1_r, border1_r, alpha1_r;
  logic signed [FRAME_C_W-1:0] fx1_r, fy1_r;
  logic signed [DELTA_W-1:0]   dx1_r, dy1_r;
  logic [RGB_W-1:0]            rgb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      hit1_r    <= hit1_nxt;
      border1_r <= border1_nxt;
      alpha1_r  <= (in_texel[COLOR_W-1:RGB_W] != '0);
      fx1_r     <= fx1_nxt;
      fy1_r     <= fy1_nxt;
      dx1_r     <= dx1_nxt;
      dy1_r     <= dy1_nxt;
      rgb1_r    <= is_bitmap ? in_texel[RGB_W-1:0] : shape_color_r[RGB_W-1:0];
    end
  end

  // stage 2: clip, shape decision, squares and row product
  logic keep2_nxt, in_frame;

  always_comb begin
    in_frame = (fx1_r >= 0) && (fx1_r < FrameW) && (fy1_r >= 0) && (fy1_r < FrameH);
    keep2_nxt = hit1_r && in_frame
                && ((is_bitmap && alpha1_r) || (is_rect && (fill_rect_r || border1_r))
                    || is_circle);
  end

  logic                keep2_r;
  logic [SQ_W-1:0]     sqx2_r, sqy2_r;
  logic [PROD_W-1:0]   prod2_r;
  logic [COORD_W-1:0]  fx2_r;
  logic [RGB_W-1:0]    rgb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1_r) begin
      keep2_r <= keep2_nxt;
      sqx2_r  <= SQ_W'(SQ_W'(dx1_r) * SQ_W'(dx1_r));
      sqy2_r  <= SQ_W'(SQ_W'(dy1_r) * SQ_W'(dy1_r));
      prod2_r <= PROD_W'(fy1_r[COORD_W-1:0]) * RowMul;
      fx2_r   <= fx1_r[COORD_W-1:0];
      rgb2_r  <= rgb1_r;
    end
  end

  // stage 3: disc test and address add
  logic              keep3_r;
  logic [PROD_W-1:0] addr3_r;
  logic [RGB_W-1:0]  rgb3_r;
  logic              disc_ok;

  assign disc_ok = ((SQ_W+1)'(sqx2_r) + (SQ_W+1)'(sqy2_r)) <= (SQ_W+1)'(radius_sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2_r) begin
      keep3_r <= keep2_r && (!is_circle || disc_ok);
      addr3_r <= prod2_r + PROD_W'(fx2_r);
      rgb3_r  <= rgb2_r;
    end
  end

  // output register, only drawn pixels become results
  logic [ADDR_W-1:0]  addr_out_r;
  logic [COLOR_W-1:0] color_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= v3_r && keep3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && v3_r) begin
      addr_out_r  <= addr3_r[ADDR_W-1:0];
      color_out_r <= {ALPHA_OPAQUE, rgb3_r};
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = addr_out_r;
  assign out_pixel_color   = color_out_r;

endmodule

/* rtl/spb_checker.sv */
// ----------------------------------------------------------------------------
// spb_checker
// Port-level checks for the sprite pixel blitter, bound to the top level.
// ----------------------------------------------------------------------------
module spb_checker #(
  parameter int FRAME_WIDTH  = spb_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = spb_pkg::DEF_FRAME_HEIGHT
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [spb_pkg::ADDR_W-1:0]    out_pixel_address,
  input logic [spb_pkg::COLOR_W-1:0]   out_pixel_color
);
  import spb_pkg::*;

  localparam logic [ADDR_W+4:0] FrameSize = (ADDR_W+5)'(FRAME_WIDTH * FRAME_HEIGHT);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_address)
                               && $stable(out_pixel_color))
    else $error("stalled result changed");

  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pixel_color[COLOR_W-1:RGB_W] == ALPHA_OPAQUE)
    else $error("result alpha not opaque");

  a_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {5'b0, out_pixel_address} < FrameSize)
    else $error("result address beyond frame");

  // an idle output never blocks a request
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !out_stall && in_valid |-> !in_stall || $past(in_stall) || $past(out_stall))
    else $error("request stalled with empty output");

endmodule

bind sprite_pixel_blit_core spb_checker #(
  .FRAME_WIDTH (FRAME_WIDTH),
  .FRAME_HEIGHT(FRAME_HEIGHT)
) u_spb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pixel_address(out_pixel_address),
  .out_pixel_color  (out_pixel_color)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sprite_pixel_blit_core. Sprite offsets stream in
// under random back-pressure; each accepted request is run through a local
// model of the blit (box test, shape test, frame clip) and the drawn pixels
// are checked in order against the address and opaque colour that come out.
// ----------------------------------------------------------------------------
module tb;
  import spb_pkg::*;

  localparam int RUN_LIMIT  = 600000;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 1750;

  typedef struct {
    logic [OFFSET_W-1:0] col;
    logic [OFFSET_W-1:0] row;
    logic [COLOR_W-1:0]  texel;
  } offset_req_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } frame_pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OFFSET_W-1:0]   in_offset_col = '0;
  logic [OFFSET_W-1:0]   in_offset_row = '0;
  logic [COLOR_W-1:0]    in_texel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ADDR_W-1:0]     out_pixel_address;
  logic [COLOR_W-1:0]    out_pixel_color;

  // register copy used by the blit model
  logic [1:0]          cur_shape = '0;
  logic [SIDE_W-1:0]   cur_width = '0;
  logic [SIDE_W-1:0]   cur_height = '0;
  logic [RADIUS_W-1:0] cur_radius = '0;
  logic [COLOR_W-1:0]  cur_color = '0;
  logic                cur_fill = 1'b0;
  logic signed [ORIGIN_W-1:0] cur_origin_x = '0;
  logic signed [ORIGIN_W-1:0] cur_origin_y = '0;

  offset_req_t  queued_offsets[$];
  frame_pixel_t expected_pixels[$];

  int          in_idle_pct = 35;
  int          out_idle_pct = 35;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  sprite_pixel_blit_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_offset_col     (in_offset_col),
    .in_offset_row     (in_offset_row),
    .in_texel          (in_texel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // whether and where one sprite pixel lands in the frame
  function automatic bit predict_blit(input logic [OFFSET_W-1:0] col,
                                      input logic [OFFSET_W-1:0] row,
                                      input logic [COLOR_W-1:0] texel,
                                      output logic [ADDR_W-1:0] addr,
                                      output logic [COLOR_W-1:0] color);
    int     side_w;
    int     side_h;
    int     fx;
    int     fy;
    longint dx;
    longint dy;
    longint rad;
    bit     draw;
    logic [COLOR_W-1:0] src;
    draw  = 1'b0;
    src   = '0;
    addr  = '0;
    color = '0;
    case (cur_shape)
      SHAPE_BITMAP, SHAPE_RECT: begin
        side_w = (int'(cur_width) > DEF_MAX_SPRITE_SIDE) ? DEF_MAX_SPRITE_SIDE
                                                         : int'(cur_width);
        side_h = (int'(cur_height) > DEF_MAX_SPRITE_SIDE) ? DEF_MAX_SPRITE_SIDE
                                                          : int'(cur_height);
      end
      SHAPE_CIRCLE: begin
        side_w = 2 * int'(cur_radius) + 1;
        if (side_w > DEF_MAX_SPRITE_SIDE) side_w = DEF_MAX_SPRITE_SIDE;
        side_h = side_w;
      end
      default: return 1'b0;
    endcase
    if (int'(col) >= side_w || int'(row) >= side_h) return 1'b0;
    fx = int'(cur_origin_x) + int'(col);
    fy = int'(cur_origin_y) + int'(row);
    if (fx < 0 || fy < 0 || fx >= DEF_FRAME_WIDTH || fy >= DEF_FRAME_HEIGHT) return 1'b0;
    case (cur_shape)
      SHAPE_BITMAP: begin
        src  = texel;
        draw = (texel[31:24] != 8'h00);
      end
      SHAPE_RECT: begin
        src  = cur_color;
        draw = cur_fill || col == 0 || row == 0 ||
               int'(col) == side_w - 1 || int'(row) == side_h - 1;
      end
      default: begin
        src  = cur_color;
        rad  = longint'(cur_radius);
        dx   = longint'(col) - rad;
        dy   = longint'(row) - rad;
        draw = (dx * dx + dy * dy <= rad * rad);
      end
    endcase
    if (!draw) return 1'b0;
    addr  = ADDR_W'(fy * DEF_FRAME_WIDTH + fx);
    color = {ALPHA_OPAQUE, src[RGB_W-1:0]};
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // driver: offers queued requests, predicts on acceptance
  always @(posedge clk) begin : drive_offsets
    offset_req_t  req;
    logic [ADDR_W-1:0]  p_addr;
    logic [COLOR_W-1:0] p_color;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_blit(in_offset_col, in_offset_row, in_texel, p_addr, p_color))
          expected_pixels.push_back('{p_addr, p_color});
      end
      if (!in_valid || !in_stall) begin
        if (queued_offsets.size() != 0 &&
            !(in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)) begin
          req = queued_offsets.pop_front();
          in_valid      <= 1'b1;
          in_offset_col <= req.col;
          in_offset_row <= req.row;
          in_texel      <= req.texel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off so the pipe backs up into the input
  always @(posedge clk) begin : hold_count
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_LEN;
    end
  end

  // monitor: checks drawn pixels and drives the output stall
  always @(posedge clk) begin : check_pixels
    frame_pixel_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel addr %0h colour %08h",
                                    out_pixel_address, out_pixel_color));
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_address !== want.addr)
            report_mismatch($sformatf("address %0h, wanted %0h",
                                      out_pixel_address, want.addr));
          if (out_pixel_color !== want.color)
            report_mismatch($sformatf("colour %08h, wanted %08h (addr %0h)",
                                      out_pixel_color, want.color, want.addr));
        end
      end
      if (hold_left > 0 || hold_req != hold_ack) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= (out_idle_pct != 0) && ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count == RUN_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  task automatic write_reg(input spb_cfg_idx_t idx, input logic [31:0] val);
    int          fw;
    logic [31:0] keep;
    logic [31:0] data;
    case (idx)
      REG_SHAPE_KIND:                fw = 2;
      REG_BOX_WIDTH, REG_BOX_HEIGHT: fw = SIDE_W;
      REG_CIRCLE_RADIUS:             fw = RADIUS_W;
      REG_SHAPE_COLOR:               fw = COLOR_W;
      REG_FILL_RECT:                 fw = 1;
      default:                       fw = ORIGIN_W;
    endcase
    keep = (fw >= 32) ? '1 : ((32'd1 << fw) - 32'd1);
    data = val & keep;
    // unused upper bits must be ignored
    if ($urandom_range(1)) data = data | ($urandom() & ~keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SHAPE_KIND:    cur_shape    = data[1:0];
      REG_BOX_WIDTH:     cur_width    = data[SIDE_W-1:0];
      REG_BOX_HEIGHT:    cur_height   = data[SIDE_W-1:0];
      REG_CIRCLE_RADIUS: cur_radius   = data[RADIUS_W-1:0];
      REG_SHAPE_COLOR:   cur_color    = data;
      REG_FILL_RECT:     cur_fill     = data[0];
      REG_ORIGIN_X:      cur_origin_x = data[ORIGIN_W-1:0];
      default:           cur_origin_y = data[ORIGIN_W-1:0];
    endcase
  endtask

  task automatic program_sprite(input int shape, input int w, input int h, input int r,
                                input logic [31:0] color, input int fill,
                                input int ox, input int oy);
    write_reg(REG_SHAPE_KIND, shape);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_CIRCLE_RADIUS, r);
    write_reg(REG_SHAPE_COLOR, color);
    write_reg(REG_FILL_RECT, fill);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(input int col, input int row, input logic [31:0] texel);
    queued_offsets.push_back('{OFFSET_W'(col), OFFSET_W'(row), texel});
  endtask

  // sender pauses until every drawn pixel is back and the pipe has emptied
  task automatic wait_drained();
    do @(posedge clk);
    while (queued_offsets.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_side();
    int k;
    k = $urandom_range(99);
    if (k < 5) return 0;
    if (k < 15) return $urandom_range(8191, 4097);
    if (k < 25) return $urandom_range(4096, 64);
    return $urandom_range(48, 1);
  endfunction

  function automatic int pick_origin(input int span);
    int k;
    k = $urandom_range(99);
    if (k < 10) return $urandom_range(65535);
    if (k < 15) return $urandom_range(1) ? 32'h0000_8000 : 32'h0000_7fff;
    return $urandom_range(span + 40) - 40;
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset(input int side);
    int k;
    k = $urandom_range(99);
    if (k < 15) return OFFSET_W'($urandom_range(4095));
    if (k < 25) return OFFSET_W'((side < 1) ? 0 : ((side > 4096) ? 4095 : side - 1));
    return OFFSET_W'($urandom_range((side + 1 > 4095) ? 4095 : side + 1));
  endfunction

  initial begin : stimulus
    int          k;
    int          n;
    int          phase;
    int          random_sent;
    int          side_c;
    logic [31:0] tx;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset state: bitmap with an empty box
    send(0, 0, 32'hffff_ffff);
    send(4095, 4095, 32'h0000_0000);
    wait_drained();

    // oversized bitmap: first pixel, clipped corner, clear texel, last address
    program_sprite(SHAPE_BITMAP, 8191, 8191, 0, 32'h0, 0, 0, 0);
    send(0, 0, 32'hff12_3456);
    send(4095, 4095, 32'hffff_ffff);
    send(5, 3, 32'h00ff_ffff);
    send(1023, 767, 32'h80ab_cdef);
    wait_drained();

    // outlined rectangle hanging off the top-left corner
    program_sprite(SHAPE_RECT, 10, 6, 0, 32'ha5c3_e1f0, 0, -3, -2);
    send(9, 5, 0);
    send(0, 4, 0);
    send(4, 3, 0);
    send(10, 0, 0);
    send(5, 0, 0);
    send(5, 5, 32'hffff_ffff);
    wait_drained();

    // filled rectangle at the bottom-right corner
    program_sprite(SHAPE_RECT, 4096, 4096, 0, 32'h1234_5678, 1, 1020, 765);
    send(3, 2, 0);
    send(4, 2, 0);
    send(3, 3, 0);
    wait_drained();

    program_sprite(SHAPE_CIRCLE, 0, 0, 5, 32'h00c0_ffee, 0, 100, 100);
    send(5, 5, 0);
    send(0, 5, 0);
    send(0, 0, 0);
    send(10, 5, 0);
    send(11, 5, 0);
    send(9, 8, 0);
    wait_drained();

    program_sprite(SHAPE_CIRCLE, 0, 0, 2047, 32'hffff_ffff, 1, -2000, -1500);
    send(2047, 2047, 0);
    send(0, 2047, 0);
    wait_drained();

    // single-pixel circle, then the undefined shape kind
    program_sprite(SHAPE_CIRCLE, 5, 5, 0, 32'h0055_aa55, 1, 0, 0);
    send(0, 0, 0);
    send(1, 0, 0);
    wait_drained();
    program_sprite(3, 5, 5, 0, 32'h0055_aa55, 1, 0, 0);
    send(0, 0, 32'hffff_ffff);
    wait_drained();

    phase = 0;
    random_sent = 0;
    while (random_sent < RAND_ITEMS) begin
      k = $urandom_range(99);
      program_sprite((k < 30) ? 0 : (k < 60) ? 1 : (k < 95) ? 2 : 3,
                     pick_side(), pick_side(),
                     ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(30),
                     $urandom(), $urandom_range(1),
                     pick_origin(DEF_FRAME_WIDTH), pick_origin(DEF_FRAME_HEIGHT));
      if (phase == 1) begin
        in_idle_pct  <= 0;
        out_idle_pct <= 35;
        hold_req     <= hold_req + 1;
        n = 150;
      end else if (phase % 5 == 3) begin
        in_idle_pct  <= 0;
        out_idle_pct <= 0;
        n = 250;
      end else begin
        in_idle_pct  <= 35;
        out_idle_pct <= 35;
        n = $urandom_range(120, 30);
      end
      side_c = (cur_shape == SHAPE_CIRCLE) ? 2 * int'(cur_radius) + 1 : int'(cur_width);
      repeat (n) begin
        tx = $urandom();
        if ($urandom_range(3) == 0) tx[31:24] = 8'h00;
        queued_offsets.push_back('{pick_offset(side_c), pick_offset(
          (cur_shape == SHAPE_CIRCLE) ? side_c : int'(cur_height)), tx});
      end
      random_sent += n;
      wait_drained();
      phase++;
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
